// ===== rtl/conv2d_valid_window_defines.svh =====
// Assertion macros for the conv2d_valid_window checker.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef CONV2D_VALID_WINDOW_DEFINES_SVH
`define CONV2D_VALID_WINDOW_DEFINES_SVH

// Same-cycle implication, checked on the rising clock, off during reset.
`define CVW_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("conv2d_valid_window check failed");

// Next-cycle implication, checked on the rising clock, off during reset.
`define CVW_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("conv2d_valid_window check failed");

`endif

// ===== rtl/cvw_pkg.sv =====
// Shared constants and request types for the conv2d_valid_window block.
// No dependencies; used by the top level and its checker.
package cvw_pkg;

  localparam int unsigned IMAGE_SIZE  = 256;
  localparam int unsigned KERNEL_SIZE = 5;
  localparam int unsigned KTAPS       = KERNEL_SIZE * KERNEL_SIZE;
  localparam int unsigned LS_ROWS     = (KERNEL_SIZE > 1) ? KERNEL_SIZE - 1 : 1;
  localparam int unsigned COORD_W     = $clog2(IMAGE_SIZE);
  localparam int unsigned KIDX_W      = (KTAPS > 1) ? $clog2(KTAPS) : 1;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned COEF_W      = 16;
  localparam int unsigned INDEX_W     = 5;
  localparam int unsigned PROD_W      = SAMPLE_W + COEF_W;
  localparam int unsigned SUM_W       = 36;
  localparam int unsigned LS_W        = LS_ROWS * SAMPLE_W;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef struct packed {
    op_e                        operation;
    logic [INDEX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0]   coef_value;
    logic signed [SAMPLE_W-1:0] sample_value;
  } in_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] window_sum;
    logic                    last_of_frame;
  } out_rsp_t;

endpackage

// ===== rtl/cvw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cvw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Read data holds while no read is issued.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/conv2d_valid_window.sv =====
// A sample request that completes a window passes through S1, S2, S3 and S4 into the
// output register, which shows its result on out_valid_o.
// Throughput: one request per cycle unless the output stalls. The line store is read at
// accept, written back as the sample leaves S1; adjacent samples never share a column.
// Reset clears counters, window and kernel; the line store is not cleared, since an
// entry is only read for a complete window after it was written in the same frame.
module conv2d_valid_window (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cvw_pkg::in_req_t in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cvw_pkg::out_rsp_t out_rsp_o
);

  localparam int unsigned K  = cvw_pkg::KERNEL_SIZE;
  localparam int unsigned SW = cvw_pkg::SAMPLE_W;

  // Pipeline: S1 holds the line store read data, S2 multiplies the window with the
  // kernel, S3 holds the products, S4 holds one partial sum per kernel row, and the
  // output register holds the finished result. A stage takes new contents whenever
  // it is empty or its contents move on, so bubbles are squeezed out.
  logic free_out, free4, free3, free2, free1;
  logic accept, in_is_sample;
  logic s1_move, s2_move;

  // Raster position of the next sample.
  logic [cvw_pkg::COORD_W-1:0] col_q, row_q;
  logic [cvw_pkg::COORD_W-1:0] col_d, row_d;
  logic has_res, is_last;

  // Stage S1.
  logic                        s1_valid_q;
  cvw_pkg::in_req_t            s1_req_q;
  logic [cvw_pkg::COORD_W-1:0] s1_col_q;
  logic                        s1_has_res_q, s1_last_q;

  // Stage S2.
  logic                        s2_valid_q;
  cvw_pkg::in_req_t            s2_req_q;
  logic                        s2_has_res_q, s2_last_q;

  // Stage S3 and S4.
  logic                             s3_valid_q, s3_last_q;
  logic signed [cvw_pkg::PROD_W-1:0] prod_q [cvw_pkg::KTAPS];
  logic signed [cvw_pkg::PROD_W-1:0] prod_d [cvw_pkg::KTAPS];
  logic                             s4_valid_q, s4_last_q;
  logic signed [cvw_pkg::SUM_W-1:0] part_q [K];
  logic signed [cvw_pkg::SUM_W-1:0] part_d [K];
  logic signed [cvw_pkg::SUM_W-1:0] total_d;

  // Output register.
  logic              out_valid_q;
  cvw_pkg::out_rsp_t out_rsp_q;

  // Line store, window and kernel.
  logic [cvw_pkg::LS_W-1:0]    ls_rdata, ls_wdata;
  logic                        ls_we, ls_re;
  logic signed [SW-1:0]        win_col [K];
  logic signed [SW-1:0]        window_q [cvw_pkg::KTAPS];
  logic signed [cvw_pkg::COEF_W-1:0] kernel_q [cvw_pkg::KTAPS];

  // ---------------------------------------------------------------------------
  // Flow control.
  // ---------------------------------------------------------------------------
  assign free_out = !out_valid_q || out_ready_i;
  assign free4    = !s4_valid_q || free_out;
  assign free3    = !s3_valid_q || free4;
  assign free2    = !s2_valid_q || free3;
  assign free1    = !s1_valid_q || free2;

  assign in_ready_o   = free1;
  assign accept       = in_valid_i && free1;
  assign in_is_sample = (in_req_i.operation == cvw_pkg::OP_SAMPLE);
  assign s1_move      = s1_valid_q && free2;
  assign s2_move      = s2_valid_q && free3;

  // ---------------------------------------------------------------------------
  // Raster counters. A window is complete once both coordinates reach the
  // kernel size minus one; the frame ends at the bottom right pixel.
  // ---------------------------------------------------------------------------
  always_comb begin
    col_d = col_q + 1'b1;
    row_d = row_q;
    if (col_q == cvw_pkg::COORD_W'(cvw_pkg::IMAGE_SIZE - 1)) begin
      col_d = '0;
      if (row_q == cvw_pkg::COORD_W'(cvw_pkg::IMAGE_SIZE - 1)) begin
        row_d = '0;
      end else begin
        row_d = row_q + 1'b1;
      end
    end
  end

  assign has_res = (row_q >= cvw_pkg::COORD_W'(K - 1)) && (col_q >= cvw_pkg::COORD_W'(K - 1));
  assign is_last = (row_q == cvw_pkg::COORD_W'(cvw_pkg::IMAGE_SIZE - 1)) &&
                   (col_q == cvw_pkg::COORD_W'(cvw_pkg::IMAGE_SIZE - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept && in_is_sample) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: one word per column holds the older window rows, oldest in the
  // low bits. It is read when a sample is accepted and written back, shifted up
  // by one row with the new sample on top, when that sample leaves S1.
  // ---------------------------------------------------------------------------
  assign ls_re = accept && in_is_sample;
  assign ls_we = s1_move && (s1_req_q.operation == cvw_pkg::OP_SAMPLE) && (K > 1);

  cvw_ram #(
    .WIDTH (cvw_pkg::LS_W),
    .DEPTH (cvw_pkg::IMAGE_SIZE)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (s1_col_q),
    .wdata_i (ls_wdata),
    .re_i    (ls_re),
    .raddr_i (col_q),
    .rdata_o (ls_rdata)
  );

  always_comb begin
    for (int fy = 0; fy < K - 1; fy++) begin
      win_col[fy] = $signed(ls_rdata[fy*SW +: SW]);
    end
    win_col[K-1] = s1_req_q.sample_value;
    for (int fy = 0; fy < cvw_pkg::LS_ROWS; fy++) begin
      if (fy + 1 < K) begin
        ls_wdata[fy*SW +: SW] = win_col[fy+1];
      end else begin
        ls_wdata[fy*SW +: SW] = '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage registers: valid bits with reset, payload without.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (free1) begin
        s1_valid_q <= in_valid_i;
      end
      if (free2) begin
        s2_valid_q <= s1_valid_q;
      end
      // Coefficient loads and incomplete windows end at S2.
      if (free3) begin
        s3_valid_q <= s2_valid_q && s2_has_res_q &&
                      (s2_req_q.operation == cvw_pkg::OP_SAMPLE);
      end
      if (free4) begin
        s4_valid_q <= s3_valid_q;
      end
      if (free_out) begin
        out_valid_q <= s4_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free1) begin
      s1_req_q     <= in_req_i;
      s1_col_q     <= col_q;
      s1_has_res_q <= has_res;
      s1_last_q    <= is_last;
    end
    if (free2) begin
      s2_req_q     <= s1_req_q;
      s2_has_res_q <= s1_has_res_q;
      s2_last_q    <= s1_last_q;
    end
    if (free3) begin
      prod_q    <= prod_d;
      s3_last_q <= s2_last_q;
    end
    if (free4) begin
      part_q    <= part_d;
      s4_last_q <= s3_last_q;
    end
    if (free_out) begin
      out_rsp_q.window_sum    <= total_d;
      out_rsp_q.last_of_frame <= s4_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Window: shifts left by one column for every sample leaving S1. The sample
  // then in S2 sees exactly its own window, since the next shift happens no
  // earlier than the edge at which it leaves S2.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cvw_pkg::KTAPS; i++) begin
        window_q[i] <= '0;
      end
    end else if (s1_move && (s1_req_q.operation == cvw_pkg::OP_SAMPLE)) begin
      for (int fy = 0; fy < K; fy++) begin
        for (int fx = 0; fx < K - 1; fx++) begin
          window_q[fy*K + fx] <= window_q[fy*K + fx + 1];
        end
        window_q[fy*K + K - 1] <= win_col[fy];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Kernel: written when a load leaves S2, so loads and samples reach the
  // multipliers in request order. Indexes beyond the kernel are dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cvw_pkg::KTAPS; i++) begin
        kernel_q[i] <= '0;
      end
    end else if (s2_move && (s2_req_q.operation == cvw_pkg::OP_LOAD) &&
                 (32'(s2_req_q.coef_index) < cvw_pkg::KTAPS)) begin
      kernel_q[cvw_pkg::KIDX_W'(s2_req_q.coef_index)] <= s2_req_q.coef_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Arithmetic: one product per tap, then one sum per kernel row, then the
  // total, each behind a register. The total wraps to the result width.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < cvw_pkg::KTAPS; i++) begin
      prod_d[i] = cvw_pkg::PROD_W'(kernel_q[i]) * cvw_pkg::PROD_W'(window_q[i]);
    end
  end

  always_comb begin
    for (int fy = 0; fy < K; fy++) begin
      part_d[fy] = '0;
      for (int fx = 0; fx < K; fx++) begin
        part_d[fy] = part_d[fy] + cvw_pkg::SUM_W'(prod_q[fy*K + fx]);
      end
    end
  end

  always_comb begin
    total_d = '0;
    for (int fy = 0; fy < K; fy++) begin
      total_d = total_d + part_q[fy];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== rtl/cvw_checker.sv =====
// Port-level checker for conv2d_valid_window, attached by a bind statement.
// Depends on cvw_pkg and conv2d_valid_window_defines.svh.
`include "conv2d_valid_window_defines.svh"

module cvw_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input cvw_pkg::out_rsp_t out_rsp_o
);

  logic in_acc, drain;

  assign in_acc = in_valid_i && in_ready_o;
  assign drain  = !in_acc && out_ready_i;

  // A waiting result holds its value until it is taken.
  `CVW_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o))

  // With the output side free, no stage can be blocked, so requests are taken.
  `CVW_ASSERT_IMPL(a_ready_when_free, !out_valid_o || out_ready_i, in_ready_o)

  // Without new requests and with every result taken, the pipeline runs empty.
  `CVW_ASSERT_NEXT(a_drain, drain ##1 drain ##1 drain ##1 drain ##1 drain, !out_valid_o)

endmodule

bind conv2d_valid_window cvw_checker u_cvw_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for conv2d_valid_window: a directed table, random requests and a
// closing stretch at full rate, all checked against a predictor in this file.
// Depends on rtl/cvw_pkg.sv and rtl/conv2d_valid_window.sv.
module tb_top;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_REQS    = 540;
  localparam int SEGMENT_LEN    = 90;
  localparam int FULL_RATE_REQS = 140;
  localparam int SETTLE_CYCLES  = 16;
  localparam int TIMEOUT_CYCLES = 2_000_000;

  // One row of the directed table. A load row with several repeats walks the coefficient
  // index upward from idx, so one row can fill the whole kernel. Where typed is set, the
  // window sum is written into the row and replaces the predicted one.
  typedef struct packed {
    cvw_pkg::op_e                        op;
    logic [cvw_pkg::INDEX_W-1:0]         idx;
    logic signed [cvw_pkg::COEF_W-1:0]   coef;
    logic signed [cvw_pkg::SAMPLE_W-1:0] smp;
    logic [11:0]                         reps;
    logic                                typed;
    logic signed [cvw_pkg::SUM_W-1:0]    sum;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  cvw_pkg::in_req_t   in_req = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  cvw_pkg::out_rsp_t  out_rsp;

  // Predictor state: kernel, cascaded line stores, window and raster position.
  logic signed [cvw_pkg::COEF_W-1:0]   coef_mem [cvw_pkg::KTAPS];
  logic signed [cvw_pkg::SAMPLE_W-1:0] line_mem [cvw_pkg::LS_ROWS][cvw_pkg::IMAGE_SIZE];
  logic signed [cvw_pkg::SAMPLE_W-1:0] win_mem  [cvw_pkg::KTAPS];
  int unsigned col_pos;
  int unsigned row_pos;

  cvw_pkg::out_rsp_t pending_sums [$];
  cvw_pkg::out_rsp_t want;

  int idle_pct;
  int stall_pct;
  int stall_left;
  int mismatches;
  int requests_sent;
  int loads_sent;
  int sums_checked;

  // The directed part. The long sample row fills rows 0 to 3 and the start of row 4, so the
  // rows after it complete windows. With every tap and every pixel at an extreme value the
  // sums are easy to read off: 2^30 for one tap, 25 * 2^30 at the top, 25 * 32767 * -32768
  // at the bottom, and zero whenever the kernel is all zero.
  dir_row_t dir_tab [22] = '{
    '{cvw_pkg::OP_LOAD,   5'd31, 16'sh7fff, 16'sh0000,   12'd1, 1'b0, 36'sd0},
    '{cvw_pkg::OP_LOAD,   5'd25, 16'sh8000, 16'shffff,   12'd1, 1'b0, 36'sd0},
    '{cvw_pkg::OP_SAMPLE, 5'd0,  16'sh5555, 16'sh8000, 12'd1028, 1'b0, 36'sd0},
    '{cvw_pkg::OP_SAMPLE, 5'd3,  16'sh0000, 16'sh8000,   12'd1, 1'b1, 36'sd0},
    '{cvw_pkg::OP_LOAD,   5'd0,  16'sh8000, 16'sh0000,   12'd1, 1'b0, 36'sd0},
    '{cvw_pkg::OP_SAMPLE, 5'd0,  16'sh0000, 16'sh8000,   12'd1, 1'b1, 36'sd1073741824},
    '{cvw_pkg::OP_LOAD,   5'd0,  16'sh8000, 16'sh7fff,  12'd25, 1'b0, 36'sd0},
    '{cvw_pkg::OP_SAMPLE, 5'd0,  16'sh0000, 16'sh8000,   12'd1, 1'b1, 36'sd26843545600},
    '{cvw_pkg::OP_LOAD,   5'd0,  16'sh7fff, 16'sh0000,  12'd25, 1'b0, 36'sd0},
    '{cvw_pkg::OP_SAMPLE, 5'd31, 16'shffff, 16'sh8000,   12'd1, 1'b1, -36'sd26842726400},
    '{cvw_pkg::OP_SAMPLE, 5'd0,  16'sh0000, 16'sh7fff,   12'd1, 1'b0, 36'sd0},
    '{cvw_pkg::OP_LOAD,   5'd12, 16'sh0000, 16'sh0000,   12'd1, 1'b0, 36'sd0},
    '{cvw_pkg::OP_LOAD,   5'd24, 16'sh4000, 16'sh0000,   12'd1, 1'b0, 36'sd0},
    '{cvw_pkg::OP_SAMPLE, 5'd0,  16'sh0000, 16'sh0000,   12'd1, 1'b0, 36'sd0},
    '{cvw_pkg::OP_SAMPLE, 5'd0,  16'sh0000, 16'sh7fff,   12'd4, 1'b0, 36'sd0},
    '{cvw_pkg::OP_LOAD,   5'd31, 16'sh0000, 16'sh1234,   12'd1, 1'b0, 36'sd0},
    '{cvw_pkg::OP_SAMPLE, 5'd0,  16'sh0000, 16'shffff,   12'd2, 1'b0, 36'sd0},
    '{cvw_pkg::OP_SAMPLE, 5'd0,  16'sh0000, 16'sh0001,   12'd1, 1'b0, 36'sd0},
    '{cvw_pkg::OP_LOAD,   5'd0,  16'sh0000, 16'sh0000,  12'd25, 1'b0, 36'sd0},
    '{cvw_pkg::OP_SAMPLE, 5'd0,  16'sh0000, 16'sh3039,   12'd1, 1'b1, 36'sd0},
    '{cvw_pkg::OP_LOAD,   5'd6,  16'shc000, 16'sh0000,   12'd1, 1'b0, 36'sd0},
    '{cvw_pkg::OP_SAMPLE, 5'd0,  16'sh0000, 16'sh7fff,   12'd1, 1'b0, 36'sd0}
  };

  conv2d_valid_window i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Advances the predictor by one accepted request. Returns 1 when the request completes a
  // window, with the expected sum and frame-end flag in rsp. The line stores start at zero
  // here, but their unwritten entries only ever reach windows that give no result.
  function automatic bit predict_window(input cvw_pkg::in_req_t r,
                                        output cvw_pkg::out_rsp_t rsp);
    logic signed [cvw_pkg::SAMPLE_W-1:0] column [cvw_pkg::KERNEL_SIZE];
    logic signed [cvw_pkg::SUM_W-1:0]    acc;
    int unsigned c;
    int unsigned rw;
    int fy;
    int fx;
    rsp = '0;
    if (r.operation == cvw_pkg::OP_LOAD) begin
      if (r.coef_index < cvw_pkg::KTAPS) begin
        coef_mem[r.coef_index] = r.coef_value;
      end
      return 1'b0;
    end
    c  = col_pos;
    rw = row_pos;
    // The new window column holds the line stores oldest first, then the new sample.
    for (fy = 0; fy < cvw_pkg::KERNEL_SIZE - 1; fy++) begin
      column[fy] = line_mem[fy][c];
    end
    column[cvw_pkg::KERNEL_SIZE-1] = r.sample_value;
    for (fy = 0; fy < cvw_pkg::KERNEL_SIZE - 1; fy++) begin
      line_mem[fy][c] = column[fy+1];
    end
    for (fy = 0; fy < cvw_pkg::KERNEL_SIZE; fy++) begin
      for (fx = 0; fx < cvw_pkg::KERNEL_SIZE - 1; fx++) begin
        win_mem[fy*cvw_pkg::KERNEL_SIZE+fx] = win_mem[fy*cvw_pkg::KERNEL_SIZE+fx+1];
      end
      win_mem[fy*cvw_pkg::KERNEL_SIZE+cvw_pkg::KERNEL_SIZE-1] = column[fy];
    end
    if (c + 1 >= cvw_pkg::IMAGE_SIZE) begin
      col_pos = 0;
      row_pos = (rw + 1 >= cvw_pkg::IMAGE_SIZE) ? 0 : rw + 1;
    end else begin
      col_pos = c + 1;
    end
    if (rw + 1 < cvw_pkg::KERNEL_SIZE || c + 1 < cvw_pkg::KERNEL_SIZE) begin
      return 1'b0;
    end
    acc = '0;
    for (fy = 0; fy < cvw_pkg::KTAPS; fy++) begin
      acc = acc + coef_mem[fy] * win_mem[fy];
    end
    rsp.window_sum    = acc;
    rsp.last_of_frame = (rw == cvw_pkg::IMAGE_SIZE - 1) && (c == cvw_pkg::IMAGE_SIZE - 1);
    return 1'b1;
  endfunction

  // Extreme values come up often enough to hit every corner of the multipliers.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(15))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly samples; loads mostly hit a real tap, the rest use an index past the kernel.
  // The field that a request does not use is filled with noise all the same.
  function automatic cvw_pkg::in_req_t random_request();
    cvw_pkg::in_req_t r;
    r.operation  = ($urandom_range(99) < 80) ? cvw_pkg::OP_SAMPLE : cvw_pkg::OP_LOAD;
    r.coef_index = ($urandom_range(99) < 85) ?
                   cvw_pkg::INDEX_W'($urandom_range(cvw_pkg::KTAPS - 1)) :
                   cvw_pkg::INDEX_W'($urandom_range(2**cvw_pkg::INDEX_W - 1, cvw_pkg::KTAPS));
    r.coef_value   = pick_word();
    r.sample_value = pick_word();
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) begin
      $display("tb_top: mismatch at %0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Offers one request, possibly after an idle burst, and holds it until it is accepted.
  // Valid stays high on return, so back-to-back requests never drop it in between.
  task automatic send_request(input cvw_pkg::in_req_t r, input bit typed,
                              input logic signed [cvw_pkg::SUM_W-1:0] typed_sum);
    cvw_pkg::out_rsp_t rsp;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    if (r.operation == cvw_pkg::OP_LOAD) begin
      loads_sent++;
    end
    if (predict_window(r, rsp)) begin
      if (typed) begin
        rsp.window_sum = typed_sum;
      end
      pending_sums.push_back(rsp);
    end
  endtask

  // Receiver: ready drops in random bursts, as often as stall_pct asks.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready  <= 1'b1;
    end
  end

  // Every accepted result is checked against the oldest expected sum.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("window sum %0d with no request waiting for it",
                                  out_rsp.window_sum));
      end else begin
        want = pending_sums.pop_front();
        sums_checked++;
        if (out_rsp.window_sum !== want.window_sum) begin
          report_mismatch($sformatf("window_sum %0d, expected %0d",
                                    out_rsp.window_sum, want.window_sum));
        end
        if (out_rsp.last_of_frame !== want.last_of_frame) begin
          report_mismatch($sformatf("last_of_frame %b, expected %b",
                                    out_rsp.last_of_frame, want.last_of_frame));
        end
      end
    end
  end

  initial begin : stimulus
    cvw_pkg::in_req_t r;
    int n;
    int k;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    foreach (win_mem[i]) win_mem[i] = '0;
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    col_pos = 0;
    row_pos = 0;
    idle_pct = 20;
    stall_pct = 20;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed table, in raster order from the top-left pixel after reset.
    foreach (dir_tab[i]) begin
      for (k = 0; k < dir_tab[i].reps; k++) begin
        r.operation    = dir_tab[i].op;
        r.coef_index   = (dir_tab[i].op == cvw_pkg::OP_LOAD) ?
                         dir_tab[i].idx + cvw_pkg::INDEX_W'(k) : dir_tab[i].idx;
        r.coef_value   = dir_tab[i].coef;
        r.sample_value = dir_tab[i].smp;
        send_request(r, dir_tab[i].typed, dir_tab[i].sum);
      end
    end

    // Random requests. Idling on each side is picked anew for every segment, so some
    // stretches run at full rate and others are full of gaps and stalls.
    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n % SEGMENT_LEN == 0) begin
        idle_pct  = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1) == 0) ? 15 : 40);
        stall_pct = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1) == 0) ? 15 : 40);
      end
      // Halfway through, hold back until the block has delivered every sum.
      if (n == RANDOM_REQS / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_sums.size() != 0) @(posedge clk);
      end
      send_request(random_request(), 1'b0, '0);
    end

    // Close with a stretch at full rate on both sides.
    idle_pct  = 0;
    stall_pct = 0;
    for (n = 0; n < FULL_RATE_REQS; n++) begin
      send_request(random_request(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d requests, %0d of them kernel loads.", requests_sent, loads_sent);
    $display("Checked %0d window sums under idle gaps, output stalls and full rate.",
             sums_checked);
    if (mismatches == 0) begin
      $display("[conv2d_valid_window] OK");
    end else begin
      $display("[conv2d_valid_window] ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("[conv2d_valid_window] ERROR");
    $finish;
  end

endmodule
